// File: hdl/otgia_pkg.sv
`timescale 1ns / 1ps

package otgia_pkg;

    // Item function codes
    localparam logic [2:0] FUNC_READ       = 3'd0;
    localparam logic [2:0] FUNC_WRITE      = 3'd1;
    localparam logic [2:0] FUNC_CORE_SRC   = 3'd2;
    localparam logic [2:0] FUNC_VBUS       = 3'd3;
    localparam logic [2:0] FUNC_SESSION    = 3'd4;
    localparam logic [2:0] FUNC_OTG_TMO    = 3'd5;
    localparam logic [2:0] FUNC_POWER_SET  = 3'd6;
    localparam logic [2:0] FUNC_POWER_DONE = 3'd7;

    // Register offsets
    localparam logic [11:0] ADDR_OTG_STATUS = 12'h80c;
    localparam logic [11:0] ADDR_OTG_TIMER  = 12'h810;
    localparam logic [11:0] ADDR_REV_A0     = 12'h814;
    localparam logic [11:0] ADDR_REV_A1     = 12'h838;
    localparam logic [11:0] ADDR_IRQ_CTRL   = 12'h83c;
    localparam logic [11:0] ADDR_CORE_PEND  = 12'h840;
    localparam logic [11:0] ADDR_CORE_SET   = 12'h844;
    localparam logic [11:0] ADDR_CORE_CLR   = 12'h848;
    localparam logic [11:0] ADDR_CORE_MASK  = 12'h84c;
    localparam logic [11:0] ADDR_DMA_PEND   = 12'h850;
    localparam logic [11:0] ADDR_DMA_SET    = 12'h854;
    localparam logic [11:0] ADDR_DMA_CLR    = 12'h858;
    localparam logic [11:0] ADDR_DMA_MASK   = 12'h85c;
    localparam logic [11:0] ADDR_GPIO_PEND  = 12'h860;
    localparam logic [11:0] ADDR_GPIO_SET   = 12'h864;
    localparam logic [11:0] ADDR_GPIO_CLR   = 12'h868;
    localparam logic [11:0] ADDR_GPIO_MASK  = 12'h86c;
    localparam logic [11:0] ADDR_TOP_PEND   = 12'h870;
    localparam logic [11:0] ADDR_TOP_SET    = 12'h874;
    localparam logic [11:0] ADDR_TOP_CLR    = 12'h878;
    localparam logic [11:0] ADDR_TOP_MASK   = 12'h87c;
    localparam logic [11:0] ADDR_REV_B0     = 12'h880;
    localparam logic [11:0] ADDR_REV_B1     = 12'h900;
    localparam logic [11:0] ADDR_DIE_ID_LO  = 12'h9f8;
    localparam logic [11:0] ADDR_DIE_ID_HI  = 12'h9fc;

    // Read-only constants
    localparam logic [31:0] REV_A_VALUE  = 32'h0000_0020;
    localparam logic [31:0] REV_B_VALUE  = 32'h0000_0030;
    localparam logic [31:0] DIE_ID_LO    = 32'ha945_3c59;
    localparam logic [31:0] DIE_ID_HI    = 32'h5405_9adf;
    localparam logic [31:0] LOW_HALF     = 32'h0000_ffff;
    localparam logic [31:0] HIGH_HALF    = 32'hffff_0000;
    localparam logic [31:0] ALL_ONES     = 32'hffff_ffff;

    // Bit positions
    localparam int BIT_DMA_DONE    = 24;
    localparam int BIT_POLARITY    = 17;
    localparam int BIT_OTG_TIMEOUT = 16;
    localparam int BIT_VBUS_CHANGE = 15;
    localparam int BIT_CORE_TX     = 9;
    localparam int BIT_CORE_RX     = 8;
    localparam int STAT_SESS_END   = 7;
    localparam int STAT_SESS_VALID = 6;
    localparam int STAT_VBUS_VALID = 5;

    typedef struct packed {
        logic [2:0]  func;
        logic [11:0] addr;
        logic [31:0] data;
        logic [4:0]  source;
        logic        level;
        logic        load_snapshot;
    } item_t;

    typedef struct packed {
        logic powered;
        logic irq_allowed;
    } pwr_status_t;

endpackage

// File: hdl/usb_otg_interrupt_aggregator.sv
`timescale 1ns / 1ps

// Interrupt aggregator for a USB OTG bridge.
//
// Input channel (in_valid / in_stall): one item per register read, register
// write or hardware event (core source, VBUS, session, OTG timeout, power).
// Output channel (out_valid / out_stall): exactly one result item per input
// item, in order: read_data (zero except for reads) and the irq level as it
// stands after that item.
//
// Datapath: input register -> decode/update logic -> result register.
// An accepted item waits in the input register; its result is then stored in
// the result register with out_valid. Throughput is one item per cycle while
// out_stall is low; the state update for an item is combinational masks and ORs.
//
// Reset (rst_n, async, active low) empties both registers and loads the
// interrupt state: all pending words zero, top mask all ones, power and
// irq-allowed flags clear. While the receiver stalls, the result register
// holds and one more item waits in the input register; in_stall rises only
// when both are occupied, and drops in the cycle the result is taken.

module usb_otg_interrupt_aggregator
    import otgia_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  func,
    input  logic [11:0] addr,
    input  logic [31:0] data,
    input  logic [4:0]  source,
    input  logic        level,
    input  logic        load_snapshot,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] read_data,
    output logic        irq
);

    logic        in_valid_reg;
    item_t       item_reg;
    logic        out_valid_reg;
    logic [31:0] rd_data_reg;
    logic        irq_reg;

    logic        advance;
    logic        in_take;
    logic [31:0] rd_data;
    logic        irq_next;
    pwr_status_t pwr;

    // Item moves into the result register when that slot is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.func          <= func;
            item_reg.addr          <= addr;
            item_reg.data          <= data;
            item_reg.source        <= source;
            item_reg.level         <= level;
            item_reg.load_snapshot <= load_snapshot;
        end
    end

    otgia_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .item     (item_reg),
        .rd_data  (rd_data),
        .irq_next (irq_next),
        .pwr      (pwr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rd_data_reg <= rd_data;
            irq_reg     <= irq_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = rd_data_reg;
    assign irq       = irq_reg;

    // The irq line can only be asserted once the power-settled event arrived
    a_irq_needs_allowed: assert property (@(posedge clk) disable iff (!rst_n)
        advance && irq_next |-> pwr.irq_allowed || item_reg.func == FUNC_POWER_DONE)
        else $error("irq asserted while interrupts not allowed");

    // Interrupts get enabled only while powered
    a_allowed_needs_power: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pwr.irq_allowed) |-> $past(pwr.powered))
        else $error("irq_allowed set while unpowered");

    // A waiting item is never dropped from the input register
    a_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("pending item lost");

    // Every processed item produces a result
    a_result_made: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result missing after item processed");

endmodule

// File: hdl/otgia_core.sv
`timescale 1ns / 1ps

module otgia_core
    import otgia_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  item_t       item,
    output logic [31:0] rd_data,
    output logic        irq_next,
    output pwr_status_t pwr
);

    logic [31:0] top_pend_reg, top_pend_next;
    logic [31:0] top_mask_reg, top_mask_next;
    logic [31:0] core_pend_reg, core_pend_next;
    logic [31:0] core_mask_reg, core_mask_next;
    logic [31:0] dma_pend_reg, dma_pend_next;
    logic [31:0] dma_mask_reg, dma_mask_next;
    logic [31:0] gpio_pend_reg, gpio_pend_next;
    logic [31:0] gpio_mask_reg, gpio_mask_next;
    logic [31:0] irq_ctrl_reg, irq_ctrl_next;
    logic [15:0] otg_stat_reg, otg_stat_next;
    logic [31:0] otg_timer_reg, otg_timer_next;
    logic        powered_reg, powered_next;
    logic        allowed_reg, allowed_next;

    logic        fold_core;
    logic        fold_dma;
    logic [15:0] vbus_stat;
    logic        any_pend;

    always_comb
    begin
        top_pend_next  = top_pend_reg;
        top_mask_next  = top_mask_reg;
        core_pend_next = core_pend_reg;
        core_mask_next = core_mask_reg;
        dma_pend_next  = dma_pend_reg;
        dma_mask_next  = dma_mask_reg;
        gpio_pend_next = gpio_pend_reg;
        gpio_mask_next = gpio_mask_reg;
        irq_ctrl_next  = irq_ctrl_reg;
        otg_stat_next  = otg_stat_reg;
        otg_timer_next = otg_timer_reg;
        powered_next   = powered_reg;
        allowed_next   = allowed_reg;
        rd_data        = '0;
        fold_core      = 1'b0;
        fold_dma       = 1'b0;
        vbus_stat      = otg_stat_reg;
        vbus_stat[STAT_VBUS_VALID] = item.level;

        unique case (item.func)
            FUNC_READ:
            begin
                unique case (item.addr) inside
                    ADDR_OTG_STATUS:             rd_data = {16'h0000, otg_stat_reg};
                    ADDR_OTG_TIMER:              rd_data = otg_timer_reg;
                    ADDR_REV_A0, ADDR_REV_A1:    rd_data = REV_A_VALUE;
                    ADDR_IRQ_CTRL:               rd_data = irq_ctrl_reg;
                    ADDR_CORE_PEND, ADDR_CORE_SET, ADDR_CORE_CLR:
                                                 rd_data = core_pend_reg;
                    ADDR_CORE_MASK:              rd_data = core_mask_reg;
                    ADDR_DMA_PEND, ADDR_DMA_SET, ADDR_DMA_CLR:
                                                 rd_data = dma_pend_reg;
                    ADDR_DMA_MASK:               rd_data = dma_mask_reg;
                    ADDR_GPIO_PEND, ADDR_GPIO_SET, ADDR_GPIO_CLR:
                                                 rd_data = gpio_pend_reg;
                    ADDR_GPIO_MASK:              rd_data = gpio_mask_reg;
                    ADDR_TOP_PEND, ADDR_TOP_SET, ADDR_TOP_CLR:
                                                 rd_data = top_pend_reg;
                    ADDR_TOP_MASK:               rd_data = top_mask_reg;
                    ADDR_REV_B0, ADDR_REV_B1:    rd_data = REV_B_VALUE;
                    ADDR_DIE_ID_LO:              rd_data = DIE_ID_LO;
                    ADDR_DIE_ID_HI:              rd_data = DIE_ID_HI;
                    default:                     rd_data = '0;
                endcase
            end
            FUNC_WRITE:
            begin
                unique case (item.addr)
                    ADDR_OTG_TIMER: otg_timer_next = item.data;
                    ADDR_IRQ_CTRL:  irq_ctrl_next  = item.data;
                    ADDR_CORE_SET:
                    begin
                        core_pend_next = core_pend_reg | item.data;
                        fold_core      = 1'b1;
                    end
                    ADDR_CORE_CLR:
                    begin
                        core_pend_next = core_pend_reg & ~item.data;
                        fold_core      = 1'b1;
                    end
                    ADDR_CORE_MASK:
                    begin
                        core_mask_next = item.data;
                        fold_core      = 1'b1;
                    end
                    ADDR_DMA_SET:
                    begin
                        dma_pend_next = dma_pend_reg | item.data;
                        fold_dma      = 1'b1;
                    end
                    ADDR_DMA_CLR:
                    begin
                        dma_pend_next = dma_pend_reg & ~item.data;
                        fold_dma      = 1'b1;
                    end
                    ADDR_DMA_MASK:
                    begin
                        dma_mask_next = item.data;
                        fold_dma      = 1'b1;
                    end
                    ADDR_GPIO_SET:  gpio_pend_next = gpio_pend_reg | item.data;
                    ADDR_GPIO_CLR:  gpio_pend_next = gpio_pend_reg & ~item.data;
                    ADDR_GPIO_MASK: gpio_mask_next = item.data;
                    ADDR_TOP_SET:   top_pend_next  = top_pend_reg | item.data;
                    ADDR_TOP_CLR:   top_pend_next  = top_pend_reg & ~item.data;
                    ADDR_TOP_MASK:  top_mask_next  = item.data;
                    default:        ;
                endcase
            end
            FUNC_CORE_SRC:
            begin
                // snapshot load does not refold the TX/RX summaries
                if (item.load_snapshot)
                begin
                    core_pend_next = item.data;
                end
                top_pend_next[item.source] = item.level;
            end
            FUNC_VBUS:
            begin
                if (vbus_stat != otg_stat_reg)
                begin
                    otg_stat_next = vbus_stat;
                    top_pend_next[BIT_VBUS_CHANGE] = 1'b1;
                end
            end
            FUNC_SESSION:
            begin
                otg_stat_next[STAT_SESS_VALID] = item.level;
                otg_stat_next[STAT_SESS_END]   = ~item.level;
            end
            FUNC_OTG_TMO:
            begin
                otg_timer_next = '0;
                top_pend_next[BIT_OTG_TIMEOUT] = 1'b1;
            end
            FUNC_POWER_SET:
            begin
                if (!item.level)
                begin
                    powered_next = 1'b0;
                end
                else if (!powered_reg)
                begin
                    powered_next = 1'b1;
                    allowed_next = 1'b0;
                end
            end
            FUNC_POWER_DONE:
            begin
                if (powered_reg)
                begin
                    allowed_next = 1'b1;
                end
            end
            default: ;
        endcase

        if (fold_core)
        begin
            top_pend_next[BIT_CORE_TX] = |(core_pend_next & LOW_HALF & ~core_mask_next);
            top_pend_next[BIT_CORE_RX] = |(core_pend_next & HIGH_HALF & ~core_mask_next);
        end
        if (fold_dma)
        begin
            top_pend_next[BIT_DMA_DONE] = |(dma_pend_next & ~dma_mask_next);
        end

        any_pend = |(top_pend_next & ~top_mask_next);
        irq_next = allowed_next & (irq_ctrl_next[BIT_POLARITY] ? any_pend : ~any_pend);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_pend_reg  <= '0;
            top_mask_reg  <= ALL_ONES;
            core_pend_reg <= '0;
            core_mask_reg <= '0;
            dma_pend_reg  <= '0;
            dma_mask_reg  <= '0;
            gpio_pend_reg <= '0;
            gpio_mask_reg <= '0;
            irq_ctrl_reg  <= '0;
            otg_stat_reg  <= '0;
            otg_timer_reg <= '0;
            powered_reg   <= 1'b0;
            allowed_reg   <= 1'b0;
        end
        else if (step)
        begin
            top_pend_reg  <= top_pend_next;
            top_mask_reg  <= top_mask_next;
            core_pend_reg <= core_pend_next;
            core_mask_reg <= core_mask_next;
            dma_pend_reg  <= dma_pend_next;
            dma_mask_reg  <= dma_mask_next;
            gpio_pend_reg <= gpio_pend_next;
            gpio_mask_reg <= gpio_mask_next;
            irq_ctrl_reg  <= irq_ctrl_next;
            otg_stat_reg  <= otg_stat_next;
            otg_timer_reg <= otg_timer_next;
            powered_reg   <= powered_next;
            allowed_reg   <= allowed_next;
        end
    end

    assign pwr.powered     = powered_reg;
    assign pwr.irq_allowed = allowed_reg;

endmodule
